/* src/pcs_pkg.sv */
// Package for the PID control step: widths, register map, reset values and
// the control word types shared by the sequencer and the datapath.
// No dependencies.
package pcs_pkg;

    localparam int ERR_BITS_DEF = 16;
    localparam int ACC_BITS_DEF = 32;
    localparam int DERIV_BITS   = 48;
    localparam int GAIN_BITS    = 16;
    localparam int DRIVE_BITS   = 32;
    localparam int DATA_BITS    = 32;
    localparam int PADDR_BITS   = 5;
    localparam int N_STEPS      = 8;
    localparam int STEP_BITS    = 3;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_GAIN_P = 3'd0;
    localparam logic [2:0] REG_GAIN_I = 3'd1;
    localparam logic [2:0] REG_GAIN_D = 3'd2;
    localparam logic [2:0] REG_TSTEP  = 3'd3;
    localparam logic [2:0] REG_TRECIP = 3'd4;

    localparam logic [GAIN_BITS-1:0] TSTEP_RESET  = 16'd3277;
    localparam logic [GAIN_BITS-1:0] TRECIP_RESET = 16'd320;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gain_p;
        logic [GAIN_BITS-1:0] gain_i;
        logic [GAIN_BITS-1:0] gain_d;
        logic [GAIN_BITS-1:0] time_step;
        logic [GAIN_BITS-1:0] time_step_recip;
    } t_cfg;

    // Multiplier operand selects.
    typedef enum logic [2:0] {
        A_TS,
        A_RECIP,
        A_KP,
        A_KI,
        A_KD
    } t_a_sel;

    typedef enum logic [1:0] {
        B_ERR,
        B_DIFF,
        B_ACC,
        B_DRV
    } t_b_sel;

    typedef enum logic [1:0] {
        T_HOLD,
        T_LOAD,
        T_ADD
    } t_tot_op;

    // Condition under which a step moves on to its target.
    typedef enum logic [1:0] {
        C_NEXT,
        C_IN,
        C_OUT
    } t_cond;

    typedef struct packed {
        t_a_sel  a_sel;
        t_b_sel  b_sel;
        logic    p_en;
        logic    acc_upd;
        logic    drv_upd;
        t_tot_op tot_op;
        logic    ld_err;
        logic    emit;
    } t_dp_ctrl;

    typedef struct packed {
        t_dp_ctrl             ctl;
        t_cond                cond;
        logic [STEP_BITS-1:0] target;
    } t_uop;

    typedef struct packed {
        t_dp_ctrl ctl;
        logic     fire;
    } t_seq_out;

endpackage

/* src/pcs_in_if.sv */
// Input channel of the PID control step: one error word per handshake.
// Depends on pcs_pkg for the default width.
interface pcs_in_if #(
    parameter int ERR_BITS = pcs_pkg::ERR_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [ERR_BITS-1:0] err_sample;

    modport source (output valid, output err_sample, input ready);
    modport sink (input valid, input err_sample, output ready);
endinterface

/* src/pcs_out_if.sv */
// Output channel of the PID control step: drive and clip flag per word.
// Depends on pcs_pkg for the drive width.
interface pcs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcs_pkg::DRIVE_BITS-1:0] drive;
    logic                                clipped;

    modport source (output valid, output drive, output clipped, input ready);
    modport sink (input valid, input drive, input clipped, output ready);
endinterface

/* src/pid_control_step.sv */
// PID control step. An error word is taken in program step zero and its result
// word is emitted in the last step of the microprogram driving the single shared
// multiplier; a new word is taken only after the last one has been emitted.
// A stalled output holds the last step until the result register frees up.
// Reset is synchronous, active low: integral, previous error and first-sample
// flag clear, the step counter returns to zero and registers take defaults.
module pid_control_step #(
    parameter int ERR_BITS = pcs_pkg::ERR_BITS_DEF,
    parameter int ACC_BITS = pcs_pkg::ACC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pcs_in_if.sink                         i_in,
    pcs_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcs_pkg::PADDR_BITS-1:0] paddr,
    input  logic [pcs_pkg::DATA_BITS-1:0]  pwdata,
    output logic [pcs_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready
);

    pcs_pkg::t_cfg     cfg;
    pcs_pkg::t_seq_out seq;
    logic              out_free;
    logic              in_ready;

    pcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcs_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_seq      (seq)
    );

    assign i_in.ready = in_ready;

    pcs_dp #(
        .ERR_BITS (ERR_BITS),
        .ACC_BITS (ACC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_seq      (seq),
        .i_err      (ERR_BITS'(i_in.err_sample)),
        .i_ready    (o_out.ready),
        .o_out_free (out_free),
        .o_valid    (o_out.valid),
        .o_drive    (o_out.drive),
        .o_clipped  (o_out.clipped)
    );

endmodule

/* src/pcs_cfg.sv */
// APB-style register file for the gains and the sample period settings.
// Depends on pcs_pkg for the register map and reset values.
module pcs_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pcs_pkg::PADDR_BITS-1:0] paddr,
    input  logic [pcs_pkg::DATA_BITS-1:0]  pwdata,
    output logic [pcs_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output pcs_pkg::t_cfg                  o_cfg
);

    pcs_pkg::t_cfg r_cfg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[pcs_pkg::PADDR_BITS-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p          <= '0;
            r_cfg.gain_i          <= '0;
            r_cfg.gain_d          <= '0;
            r_cfg.time_step       <= pcs_pkg::TSTEP_RESET;
            r_cfg.time_step_recip <= pcs_pkg::TRECIP_RESET;
        end else if (wr) begin
            unique case (idx)
                pcs_pkg::REG_GAIN_P: r_cfg.gain_p <= pwdata[pcs_pkg::GAIN_BITS-1:0];
                pcs_pkg::REG_GAIN_I: r_cfg.gain_i <= pwdata[pcs_pkg::GAIN_BITS-1:0];
                pcs_pkg::REG_GAIN_D: r_cfg.gain_d <= pwdata[pcs_pkg::GAIN_BITS-1:0];
                pcs_pkg::REG_TSTEP:  r_cfg.time_step <= pwdata[pcs_pkg::GAIN_BITS-1:0];
                pcs_pkg::REG_TRECIP: begin
                    r_cfg.time_step_recip <= pwdata[pcs_pkg::GAIN_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            pcs_pkg::REG_GAIN_P: prdata = pcs_pkg::DATA_BITS'(r_cfg.gain_p);
            pcs_pkg::REG_GAIN_I: prdata = pcs_pkg::DATA_BITS'(r_cfg.gain_i);
            pcs_pkg::REG_GAIN_D: prdata = pcs_pkg::DATA_BITS'(r_cfg.gain_d);
            pcs_pkg::REG_TSTEP:  prdata = pcs_pkg::DATA_BITS'(r_cfg.time_step);
            pcs_pkg::REG_TRECIP: prdata = pcs_pkg::DATA_BITS'(r_cfg.time_step_recip);
            default:             prdata = '0;
        endcase
    end

endmodule

/* src/pcs_seq.sv */
// Microprogram sequencer: step counter, control store and jump logic.
// Depends on pcs_pkg for the control word types.
module pcs_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    output logic              o_in_ready,
    output pcs_pkg::t_seq_out o_seq
);

    logic [pcs_pkg::STEP_BITS-1:0] r_step;
    logic [pcs_pkg::STEP_BITS-1:0] n_step;
    pcs_pkg::t_uop                 uop;
    logic                          met;

    // Control store. The multiplier result of one step is consumed by the
    // next, which issues the following multiplication in the same cycle.
    function automatic pcs_pkg::t_uop f_rom(input logic [pcs_pkg::STEP_BITS-1:0] s);
        pcs_pkg::t_uop w;
        w = '0;
        w.ctl.a_sel  = pcs_pkg::A_TS;
        w.ctl.b_sel  = pcs_pkg::B_ERR;
        w.ctl.tot_op = pcs_pkg::T_HOLD;
        w.cond       = pcs_pkg::C_NEXT;
        w.target     = s + 1'b1;
        unique case (s)
            3'd0: begin
                w.ctl.ld_err = 1'b1;
                w.cond       = pcs_pkg::C_IN;
            end
            3'd1: begin
                w.ctl.p_en = 1'b1;
            end
            3'd2: begin
                w.ctl.acc_upd = 1'b1;
                w.ctl.a_sel   = pcs_pkg::A_RECIP;
                w.ctl.b_sel   = pcs_pkg::B_DIFF;
                w.ctl.p_en    = 1'b1;
            end
            3'd3: begin
                w.ctl.drv_upd = 1'b1;
                w.ctl.a_sel   = pcs_pkg::A_KP;
                w.ctl.p_en    = 1'b1;
            end
            3'd4: begin
                w.ctl.tot_op = pcs_pkg::T_LOAD;
                w.ctl.a_sel  = pcs_pkg::A_KI;
                w.ctl.b_sel  = pcs_pkg::B_ACC;
                w.ctl.p_en   = 1'b1;
            end
            3'd5: begin
                w.ctl.tot_op = pcs_pkg::T_ADD;
                w.ctl.a_sel  = pcs_pkg::A_KD;
                w.ctl.b_sel  = pcs_pkg::B_DRV;
                w.ctl.p_en   = 1'b1;
            end
            3'd6: begin
                w.ctl.tot_op = pcs_pkg::T_ADD;
            end
            3'd7: begin
                w.ctl.emit = 1'b1;
                w.cond     = pcs_pkg::C_OUT;
                w.target   = '0;
            end
            default: ;
        endcase
        return w;
    endfunction

    assign uop = f_rom(r_step);

    always_comb begin
        unique case (uop.cond)
            pcs_pkg::C_NEXT: met = 1'b1;
            pcs_pkg::C_IN:   met = i_in_valid;
            pcs_pkg::C_OUT:  met = i_out_free;
            default:         met = 1'b0;
        endcase
        n_step = met ? uop.target : r_step;
    end

    assign o_in_ready = (uop.cond == pcs_pkg::C_IN);
    assign o_seq.ctl  = uop.ctl;
    assign o_seq.fire = met;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* src/pcs_dp.sv */
// Datapath of the PID control step: shared multiplier, integral, derivative,
// running total and the output register. Depends on pcs_pkg.
module pcs_dp #(
    parameter int ERR_BITS = pcs_pkg::ERR_BITS_DEF,
    parameter int ACC_BITS = pcs_pkg::ACC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pcs_pkg::t_cfg                         i_cfg,
    input  pcs_pkg::t_seq_out                     i_seq,
    input  logic signed [ERR_BITS-1:0]            i_err,
    input  logic                                  i_ready,
    output logic                                  o_out_free,
    output logic                                  o_valid,
    output logic signed [pcs_pkg::DRIVE_BITS-1:0] o_drive,
    output logic                                  o_clipped
);

    localparam int DW  = pcs_pkg::DERIV_BITS;
    localparam int OW  = pcs_pkg::DRIVE_BITS;
    localparam int MA  = pcs_pkg::GAIN_BITS + 1;
    localparam int MB0 = (ERR_BITS + 1 > ACC_BITS) ? ERR_BITS + 1 : ACC_BITS;
    localparam int MB  = (MB0 > DW) ? MB0 : DW;
    localparam int PW  = MA + MB;
    localparam int TW  = PW + 2;

    logic signed [ERR_BITS-1:0] r_err;
    logic signed [ERR_BITS-1:0] r_last;
    logic                       r_primed;
    logic signed [ACC_BITS-1:0] r_accum;
    logic signed [DW-1:0]       r_deriv;
    logic signed [PW-1:0]       r_prod;
    logic signed [TW-1:0]       r_total;
    logic                       r_hit;
    logic                       r_out_valid;
    logic signed [OW-1:0]       r_drive;
    logic                       r_clip;

    logic signed [ERR_BITS:0]   diff;
    logic signed [MA-1:0]       mul_a;
    logic signed [MB-1:0]       mul_b;
    logic signed [PW-1:0]       prod;
    logic signed [PW:0]         acc_sum;
    logic                       acc_fit;
    logic signed [ACC_BITS-1:0] acc_sat;
    logic signed [PW+3:0]       drv_shift;
    logic                       drv_fit;
    logic signed [DW-1:0]       drv_sat;
    logic                       tot_fit;
    logic signed [OW-1:0]       tot_sat;
    logic                       fire;

    assign fire = i_seq.fire;

    // Before the first sample the previous error is taken as the current one.
    assign diff = r_primed ? ((ERR_BITS+1)'(r_err) - (ERR_BITS+1)'(r_last)) : '0;

    always_comb begin
        unique case (i_seq.ctl.a_sel)
            pcs_pkg::A_TS:    mul_a = signed'({1'b0, i_cfg.time_step});
            pcs_pkg::A_RECIP: mul_a = signed'({1'b0, i_cfg.time_step_recip});
            pcs_pkg::A_KP:    mul_a = MA'(signed'(i_cfg.gain_p));
            pcs_pkg::A_KI:    mul_a = MA'(signed'(i_cfg.gain_i));
            pcs_pkg::A_KD:    mul_a = MA'(signed'(i_cfg.gain_d));
            default:          mul_a = '0;
        endcase
        unique case (i_seq.ctl.b_sel)
            pcs_pkg::B_ERR:  mul_b = MB'(r_err);
            pcs_pkg::B_DIFF: mul_b = MB'(diff);
            pcs_pkg::B_ACC:  mul_b = MB'(r_accum);
            pcs_pkg::B_DRV:  mul_b = MB'(r_deriv);
            default:         mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    // Integral update, saturated to the accumulator width.
    assign acc_sum = (PW+1)'(r_accum) + (PW+1)'(r_prod >>> 8);
    assign acc_fit = (acc_sum[PW:ACC_BITS-1] == {(PW-ACC_BITS+2){acc_sum[PW]}});
    assign acc_sat = acc_fit ? acc_sum[ACC_BITS-1:0]
                   : (acc_sum[PW] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                  : {1'b0, {(ACC_BITS-1){1'b1}}});

    // Derivative taken to Q40.8 by a shift of four, then saturated.
    assign drv_shift = (PW+4)'(r_prod) <<< 4;
    assign drv_fit   = (drv_shift[PW+3:DW-1] == {(PW+5-DW){drv_shift[PW+3]}});
    assign drv_sat   = drv_fit ? drv_shift[DW-1:0]
                     : (drv_shift[PW+3] ? {1'b1, {(DW-1){1'b0}}}
                                        : {1'b0, {(DW-1){1'b1}}});

    assign tot_fit = (r_total[TW-1:OW-1] == {(TW-OW+1){r_total[TW-1]}});
    assign tot_sat = tot_fit ? r_total[OW-1:0]
                   : (r_total[TW-1] ? {1'b1, {(OW-1){1'b0}}}
                                    : {1'b0, {(OW-1){1'b1}}});

    assign o_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_drive    = r_drive;
    assign o_clipped  = r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_last      <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_seq.ctl.acc_upd && fire) begin
                r_accum <= acc_sat;
            end
            if (i_seq.ctl.emit && fire) begin
                r_last      <= r_err;
                r_primed    <= 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (i_seq.ctl.ld_err) begin
                r_err <= i_err;
            end
            if (i_seq.ctl.p_en) begin
                r_prod <= prod;
            end
            if (i_seq.ctl.drv_upd) begin
                r_deriv <= drv_sat;
            end
            case (i_seq.ctl.tot_op)
                pcs_pkg::T_LOAD: r_total <= TW'(r_prod);
                pcs_pkg::T_ADD:  r_total <= r_total + TW'(r_prod >>> 8);
                default: ;
            endcase
            if (i_seq.ctl.ld_err) begin
                r_hit <= 1'b0;
            end else if (i_seq.ctl.acc_upd) begin
                r_hit <= r_hit | !acc_fit;
            end else if (i_seq.ctl.drv_upd) begin
                r_hit <= r_hit | !drv_fit;
            end
            if (i_seq.ctl.emit) begin
                r_drive <= tot_sat;
                r_clip  <= r_hit | !tot_fit;
            end
        end
    end

endmodule
